// File: hw/rtl/brr_pkg.sv
// shared types, constants and filter coefficients for the brr block decoder
`default_nettype none
package brr_pkg;

   localparam int HEADER_W = 8;
   localparam int DATA_W = 64;
   localparam int SAMPLE_W = 16;
   localparam int NIB_W = 4;
   localparam int NIBBLES = DATA_W / NIB_W;
   localparam int NIB_IDX_W = $clog2(NIBBLES);
   localparam int SHIFT_W = 4;
   localparam int SEL_W = 2;
   localparam int COEF_W = 8;
   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int PRED_W = PROD_W + 1;
   localparam int COEF_FRAC = 6;

   // header fields
   localparam int SHIFT_LSB = 4;
   localparam int SEL_LSB = 2;

   // block queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [NIB_IDX_W-1:0] LAST_NIB = NIB_IDX_W'(NIBBLES - 1);

   // prediction coefficients in units of 1/64
   localparam logic signed [COEF_W-1:0] COEF_A [4] = '{8'sd0, 8'sd60, 8'sd122, 8'sd115};
   localparam logic signed [COEF_W-1:0] COEF_B [4] = '{8'sd0, 8'sd0, -8'sd60, -8'sd52};

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [SEL_W-1:0]   sel;
      logic [DATA_W-1:0]  data;
   } block_type;

   typedef struct packed {
      logic      valid;
      block_type blk;
   } block_beat_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
   } front_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage
`default_nettype wire

// File: hw/rtl/brr_block_decoder_top.sv
// a block beat taken with the queue empty and the back end idle is written into the queue,
// loaded into the sequencer and decoded into the output register, which raises rsp_valid with
// its first sample; throughput: one sample beat per cycle while rsp_stall does not hold the
// output, set by the prediction filter loop where each sample needs the one decoded just
// before it; reset (synchronous, active high) empties the block queue, stops the sequencer,
// drops rsp_valid and clears both history samples to zero
`default_nettype none
module brr_block_decoder_top
   import brr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // compressed block beats
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [HEADER_W-1:0]   req_header_byte,
   input  wire logic [DATA_W-1:0]     req_data_word,
   // decoded sample beats
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last_of_block
);

   // queued block handed from front to back
   block_beat_type   blk_beat;
   logic             blk_take;
   front_status_type front_status;
   back_status_type  back_status;

   // front: header split and a two-deep block queue, so a new block is taken
   // while the back end is still decoding the one before
   brr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_header_byte (req_header_byte),
      .req_data_word   (req_data_word),
      .blk_out         (blk_beat),
      .blk_take        (blk_take),
      .status          (front_status)
   );

   // back: walks the sixteen nibbles into an output register, one filter step per cycle while
   // rsp_stall does not hold it; loads the next block on the cycle of the last nibble
   brr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .blk_in            (blk_beat),
      .blk_take          (blk_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_last_of_block (rsp_last_of_block),
      .status            (back_status)
   );

   // queue never holds more blocks than it has entries
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("block queue over its depth");

   // a beat taken into an empty queue is still visible there next cycle
   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && front_status.count == '0) |=> front_status.count != '0)
      else $error("pushed block lost from queue");

   // once the sequencer is idle, only the last sample of a block may remain
   a_idle_tail: assert property (@(posedge clock) disable iff (reset)
      !back_status.busy |-> (!rsp_valid || rsp_last_of_block))
      else $error("sequencer idle in the middle of a block");

endmodule
`default_nettype wire

// File: hw/rtl/brr_front.sv
// front end: takes block beats, splits the header and queues blocks
`default_nettype none
module brr_front
   import brr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [HEADER_W-1:0]   req_header_byte,
   input  wire logic [DATA_W-1:0]     req_data_word,
   output block_beat_type             blk_out,
   input  wire logic                  blk_take,
   output front_status_type           status
);

   block_type              queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;
   block_type              new_blk;

   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign pop = blk_out.valid && blk_take;

   // header classification
   always_comb begin
      new_blk.shift = req_header_byte[SHIFT_LSB +: SHIFT_W];
      new_blk.sel = req_header_byte[SEL_LSB +: SEL_W];
      new_blk.data = req_data_word;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_blk;
      end
   end

   assign blk_out.valid = (count_ff != '0);
   assign blk_out.blk = queue_mem[rd_ptr_ff];
   assign status.count = count_ff;

endmodule
`default_nettype wire

// File: hw/rtl/brr_back.sv
// back end: nibble sequencer and second-order prediction filter
`default_nettype none
module brr_back
   import brr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire block_beat_type        blk_in,
   output logic                       blk_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last_of_block,
   output back_status_type            status
);

   logic                        busy_ff, busy_in;
   logic [NIB_IDX_W-1:0]        idx_ff, idx_in;
   logic [SHIFT_W-1:0]          shift_ff, shift_in;
   logic [SEL_W-1:0]            sel_ff, sel_in;
   logic [DATA_W-1:0]           data_ff, data_in;
   logic signed [SAMPLE_W-1:0]  prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0]  older_ff, older_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                        out_last_ff, out_last_in;

   logic                        advance;
   logic                        step;
   logic                        last_nib;
   logic signed [NIB_W-1:0]     nib;
   logic [SAMPLE_W-1:0]         term;
   logic signed [PROD_W-1:0]    prod_a;
   logic signed [PROD_W-1:0]    prod_b;
   logic signed [PRED_W-1:0]    pred_sum;
   logic signed [PRED_W-1:0]    pred_floor;
   logic [SAMPLE_W-1:0]         new_sample;

   assign advance = !out_valid_ff || !rsp_stall;
   assign step = busy_ff && advance;
   assign last_nib = (idx_ff == LAST_NIB);
   assign blk_take = blk_in.valid && (!busy_ff || (step && last_nib));

   // one filter step: nibble scaled by shift plus floored prediction
   always_comb begin
      nib = data_ff[DATA_W-1 -: NIB_W];
      term = {{(SAMPLE_W - NIB_W){nib[NIB_W-1]}}, nib} << shift_ff;
      prod_a = PROD_W'(COEF_A[sel_ff]) * PROD_W'(prev_ff);
      prod_b = PROD_W'(COEF_B[sel_ff]) * PROD_W'(older_ff);
      pred_sum = PRED_W'(prod_a) + PRED_W'(prod_b);
      pred_floor = pred_sum >>> COEF_FRAC;
      new_sample = term + pred_floor[SAMPLE_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      shift_in = shift_ff;
      sel_in = sel_ff;
      data_in = data_ff;
      prev_in = prev_ff;
      older_in = older_ff;
      out_valid_in = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_last_in = out_last_ff;
      if (advance) begin
         out_valid_in = busy_ff;
      end
      if (step) begin
         out_sample_in = new_sample;
         out_last_in = last_nib;
         older_in = prev_ff;
         prev_in = new_sample;
         data_in = data_ff << NIB_W;
         idx_in = idx_ff + 1'b1;
         if (last_nib) begin
            busy_in = 1'b0;
         end
      end
      if (blk_take) begin
         busy_in = 1'b1;
         idx_in = '0;
         shift_in = blk_in.blk.shift;
         sel_in = blk_in.blk.sel;
         data_in = blk_in.blk.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         prev_ff <= '0;
         older_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         prev_ff <= prev_in;
         older_ff <= older_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      sel_ff <= sel_in;
      data_ff <= data_in;
      out_sample_ff <= out_sample_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last_of_block = out_last_ff;
   assign status.busy = busy_ff;

endmodule
`default_nettype wire

// File: tb/sv/brr_block_decoder_top_test.sv
// self-checking testbench for the brr block decoder top level
`timescale 1ns / 1ps
module brr_block_decoder_top_test
   import brr_pkg::*;
;

   // filter select codes carried in header bits 3..2
   typedef enum logic [SEL_W-1:0] {
      SEL_FLAT      = 2'd0,
      SEL_ONE_TAP   = 2'd1,
      SEL_TWO_TAP_A = 2'd2,
      SEL_TWO_TAP_B = 2'd3
   } filter_sel_type;

   typedef struct {
      logic [HEADER_W-1:0] header;
      logic [DATA_W-1:0]   data;
      bit                  drain_first;   // hold off until every sample is back
   } block_item_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } sample_beat_type;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int REPORT_MAX = 10;
   localparam int RANDOM_BLOCKS = 194;
   localparam int QUIET_FROM = 600;        // window with no idling on either side
   localparam int QUIET_TO = 1600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [HEADER_W-1:0] req_header_byte = '0;
   logic [DATA_W-1:0] req_data_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic rsp_last_of_block;

   block_item_type  blocks_to_send[$];
   sample_beat_type expected_samples[$];

   // decoder history as the predictor sees it
   logic signed [SAMPLE_W-1:0] last_sample = '0;
   logic signed [SAMPLE_W-1:0] older_sample = '0;

   int cycle_count = 0;
   int mismatch_count = 0;

   brr_block_decoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_header_byte   (req_header_byte),
      .req_data_word     (req_data_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_last_of_block (rsp_last_of_block)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor: decode one block into sixteen expected sample beats
   // ------------------------------------------------------------------
   function automatic void decode_block(logic [HEADER_W-1:0] header, logic [DATA_W-1:0] data);
      logic [SHIFT_W-1:0] shift;
      filter_sel_type sel;
      int coef_last, coef_older;
      logic signed [NIB_W-1:0] nib;
      int term, acc, pred, sum;
      sample_beat_type beat;
      shift = header[7:4];
      sel = filter_sel_type'(header[3:2]);
      case (sel)
         SEL_FLAT: begin
            coef_last = 0;    coef_older = 0;
         end
         SEL_ONE_TAP: begin
            coef_last = 60;   coef_older = 0;
         end
         SEL_TWO_TAP_A: begin
            coef_last = 122;  coef_older = -60;
         end
         default: begin
            coef_last = 115;  coef_older = -52;
         end
      endcase
      for (int k = 0; k < NIBBLES; k++) begin
         // high nibble of the first byte comes out first
         nib = data[DATA_W-1-NIB_W*k -: NIB_W];
         term = int'(nib) * (1 << shift);
         acc = coef_last * int'(last_sample) + coef_older * int'(older_sample);
         // arithmetic shift floors toward minus infinity, as the filter wants
         pred = acc >>> COEF_FRAC;
         sum = term + pred;
         older_sample = last_sample;
         last_sample = sum[SAMPLE_W-1:0];   // wraps, no saturation
         beat.sample = last_sample;
         beat.last = (k == NIBBLES - 1);
         expected_samples.push_back(beat);
      end
   endfunction

   function automatic bit quiet_window();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   function automatic bit roll_idle();
      return !quiet_window() && ($urandom_range(0, 99) < 11);
   endfunction

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------
   // driver: presents pending blocks, holds a stalled beat steady
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // beat taken at this edge goes to the predictor
         if (req_valid && !req_stall)
            decode_block(req_header_byte, req_data_word);
         if (!req_valid || !req_stall) begin
            if (blocks_to_send.size() > 0 && !roll_idle() &&
                !(blocks_to_send[0].drain_first && expected_samples.size() > 0)) begin
               req_valid <= 1'b1;
               req_header_byte <= blocks_to_send[0].header;
               req_data_word <= blocks_to_send[0].data;
               void'(blocks_to_send.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: checks each sample beat against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sample_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected sample beat: sample=%0d last=%0b",
                           rsp_sample, rsp_last_of_block);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample || rsp_last_of_block !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"sample mismatch: expected sample=%0d last=%0b, ",
                               "got sample=%0d last=%0b"},
                              want.sample, want.last, rsp_sample, rsp_last_of_block);
               end
            end
         end
         rsp_stall <= roll_idle();
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic logic [HEADER_W-1:0] make_header(int shift, filter_sel_type sel, int low);
      return {4'(shift), sel, 2'(low)};
   endfunction

   function automatic void add_block(logic [HEADER_W-1:0] header, logic [DATA_W-1:0] data,
                                     bit drain_first = 1'b0);
      block_item_type item;
      item.header = header;
      item.data = data;
      item.drain_first = drain_first;
      blocks_to_send.push_back(item);
   endfunction

   initial begin
      int pick;
      filter_sel_type sel;
      logic [DATA_W-1:0] data;

      // directed: every filter, shift extremes, nibble extremes
      add_block(make_header(0, SEL_FLAT, 0), 64'h0123_4567_89AB_CDEF);
      add_block(make_header(0, SEL_ONE_TAP, 0), 64'h0123_4567_89AB_CDEF);
      add_block(make_header(0, SEL_TWO_TAP_A, 0), 64'h0123_4567_89AB_CDEF);
      add_block(make_header(0, SEL_TWO_TAP_B, 0), 64'hFEDC_BA98_7654_3210);
      add_block(make_header(15, SEL_FLAT, 0), 64'h8888_8888_8888_8888);
      add_block(make_header(15, SEL_ONE_TAP, 0), 64'h7777_7777_7777_7777);
      // large shifts leave sixteen bits and wrap
      add_block(make_header(13, SEL_TWO_TAP_A, 1), 64'h7878_7878_7878_7878);
      add_block(make_header(14, SEL_TWO_TAP_B, 2), 64'h8787_8787_8787_8787);
      // history built up by the filter pushes the sum past the 16-bit range
      add_block(make_header(12, SEL_TWO_TAP_A, 0), 64'h7777_7777_7777_7777, 1'b1);
      add_block(make_header(12, SEL_TWO_TAP_B, 0), 64'h7777_7777_7777_7777);
      add_block(make_header(12, SEL_TWO_TAP_B, 0), 64'h8888_8888_8888_8888);
      add_block(make_header(0, SEL_TWO_TAP_A, 0), 64'hFFFF_FFFF_FFFF_FFFF);
      // low header bits must not matter
      add_block(make_header(3, SEL_TWO_TAP_A, 3), 64'h1F2E_3D4C_5B6A_7980);
      add_block(make_header(3, SEL_TWO_TAP_A, 0), 64'h1F2E_3D4C_5B6A_7980);
      // zero input lets the history decay
      add_block(8'h00, 64'h0);
      add_block(make_header(0, SEL_TWO_TAP_B, 0), 64'h0);
      add_block(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(make_header(1, SEL_ONE_TAP, 2), 64'h0);

      // random: mostly realistic shifts, some large ones, some raw headers
      for (int i = 0; i < RANDOM_BLOCKS; i++) begin
         pick = $urandom_range(0, 99);
         sel = filter_sel_type'($urandom_range(0, 3));
         data = {$urandom, $urandom};
         if (pick < 70)
            add_block(make_header($urandom_range(0, 12), sel, $urandom_range(0, 3)), data,
                      i == 90);
         else if (pick < 85)
            add_block(make_header($urandom_range(13, 15), sel, $urandom_range(0, 3)), data);
         else
            add_block(8'($urandom), data);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every block handed over, then every sample back
      while (blocks_to_send.size() > 0 || req_valid)
         @(posedge clock);
      while (expected_samples.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: brr_block_decoder_top.f
hw/rtl/brr_pkg.sv
hw/rtl/brr_front.sv
hw/rtl/brr_back.sv
hw/rtl/brr_block_decoder_top.sv
tb/sv/brr_block_decoder_top_test.sv
